>>> src/jse_pkg.sv
// Package for the JSON string escaper: item structs, the work descriptor
// passed from the front end to the back end, character constants and helpers.
// No dependencies.
`default_nettype none

package jse_pkg;

  // Input item: one string byte or the end of the string.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  // Output item: one character of escaped JSON text.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_done;
    logic       run_last;
  } out_item_t;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Number of UTF-8 bytes that can be held while a sequence is open.
  localparam int unsigned HeldDepth = 3;
  localparam int unsigned HeldIdxW  = 2;
  localparam int unsigned SeqLenW   = 3;

  // Depth of the descriptor queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  // Characters.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;

  // UTF-8 limits.
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead4Max   = 8'hF4;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] SecondA0   = 8'hA0;
  localparam logic [7:0] Second90   = 8'h90;
  localparam logic [7:0] CtrlLimit  = 8'h20;
  localparam logic [7:0] AsciiLimit = 8'h80;

  // Last character offset inside a six-character \u00XX escape.
  localparam logic [2:0] HexEscLast   = 3'd5;
  localparam logic [2:0] ShortEscLast = 3'd1;

  // What follows the held bytes in one item's output.
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_PASS,
    TAIL_SHORT,
    TAIL_HEX,
    TAIL_CLOSE
  } tail_e;

  // Work for one input item, as decided by the front end.
  typedef struct packed {
    logic                            open_quote;
    logic [HeldDepth-1:0][7:0]       held;
    logic [HeldIdxW-1:0]             held_n;
    logic                            held_esc;
    tail_e                           tail;
    logic [7:0]                      tail_byte;
  } desc_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ChZero + {4'h0, nib};
    end else begin
      ch = ChLowerA + {4'h0, nib} - 8'd10;
    end
    return ch;
  endfunction

  // Second character of a short escape, or zero when there is none.
  function automatic logic [7:0] short_esc(input logic [7:0] c);
    logic [7:0] e;
    case (c)
      8'h22:   e = 8'h22;
      8'h5C:   e = 8'h5C;
      8'h08:   e = 8'h62;
      8'h0C:   e = 8'h66;
      8'h0A:   e = 8'h6E;
      8'h0D:   e = 8'h72;
      8'h09:   e = 8'h74;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

>>> src/jse_front.sv
// Front end of the JSON string escaper: accepts items, tracks the UTF-8
// sequence state and writes one work descriptor per item that gives output.
// Depends on jse_pkg.
`default_nettype none

module jse_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jse_pkg::in_item_t in_item_i,
  input  logic             full_i,
  output logic             push_o,
  output jse_pkg::desc_t   desc_o
);
  import jse_pkg::*;

  logic                           inside_q, inside_d;
  logic [HeldDepth-1:0][7:0]      held_q, held_d;
  logic [HeldIdxW-1:0]            hc_q, hc_d;
  logic [SeqLenW-1:0]             sl_q, sl_d;

  logic                  accept;
  logic [HeldIdxW-1:0]   hc_eff;
  logic [7:0]            c;
  logic [7:0]            lead;
  logic [7:0]            esc;
  logic                  cont;
  logic                  range_bad;
  logic                  do_fresh;
  logic [SeqLenW-1:0]    need;
  desc_t                 desc;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign c          = in_item_i.data_byte;
  assign lead       = held_q[0];
  assign hc_eff     = inside_q ? hc_q : '0;
  assign esc        = short_esc(c);
  assign cont       = (c[7:6] == 2'b10);

  // A second byte outside the allowed range for its lead breaks the sequence.
  assign range_bad = (hc_eff == 2'd1) &&
                     (((lead == LeadE0) && (c <  SecondA0)) ||
                      ((lead == LeadED) && (c >= SecondA0)) ||
                      ((lead == LeadF0) && (c <  Second90)) ||
                      ((lead == Lead4Max) && (c >= Second90)));

  // Sequence length announced by a lead byte, zero when it is no lead.
  always_comb begin
    need = '0;
    if ((c >= Lead2Min) && (c[7:5] == 3'b110)) begin
      need = 3'd2;
    end else if (c[7:4] == 4'hE) begin
      need = 3'd3;
    end else if ((c[7:3] == 5'b11110) && (c <= Lead4Max)) begin
      need = 3'd4;
    end
  end

  // Classify the item and work out the next sequence state.
  always_comb begin
    desc.open_quote = !inside_q;
    desc.held       = held_q;
    desc.held_n     = '0;
    desc.held_esc   = 1'b1;
    desc.tail       = TAIL_NONE;
    desc.tail_byte  = c;
    inside_d        = 1'b1;
    held_d          = held_q;
    hc_d            = hc_eff;
    sl_d            = inside_q ? sl_q : '0;
    do_fresh        = 1'b0;

    if (in_item_i.kind == KindEnd) begin
      // Flush anything cut off, then close the literal.
      desc.held_n = hc_eff;
      desc.tail   = TAIL_CLOSE;
      inside_d    = 1'b0;
      hc_d        = '0;
      sl_d        = '0;
    end else if (hc_eff == '0) begin
      do_fresh = 1'b1;
    end else if (!cont || range_bad) begin
      // Broken sequence: escape the held bytes and restart on this byte.
      desc.held_n = hc_eff;
      hc_d        = '0;
      sl_d        = '0;
      do_fresh    = 1'b1;
    end else if (({1'b0, hc_eff} + 3'd1) >= sl_q) begin
      // Sequence complete: all held bytes and this one pass unchanged.
      desc.held_n   = hc_eff;
      desc.held_esc = 1'b0;
      desc.tail     = TAIL_PASS;
      hc_d          = '0;
      sl_d          = '0;
    end else if (hc_eff != 2'd3) begin
      held_d[hc_eff] = c;
      hc_d           = hc_eff + 2'd1;
    end

    if (do_fresh) begin
      if (esc != 8'h00) begin
        desc.tail      = TAIL_SHORT;
        desc.tail_byte = esc;
      end else if (c < CtrlLimit) begin
        desc.tail = TAIL_HEX;
      end else if (c < AsciiLimit) begin
        desc.tail = TAIL_PASS;
      end else if (need == '0) begin
        desc.tail = TAIL_HEX;
      end else begin
        held_d[0] = c;
        hc_d      = 2'd1;
        sl_d      = need;
      end
    end
  end

  assign desc_o = desc;
  assign push_o = accept &&
                  (desc.open_quote || (desc.held_n != '0) || (desc.tail != TAIL_NONE));

  // Sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      hc_q     <= '0;
      sl_q     <= '0;
    end else if (accept) begin
      inside_q <= inside_d;
      hc_q     <= hc_d;
      sl_q     <= sl_d;
    end
  end

  // Held bytes carry no reset; only entries below the count are read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> src/jse_queue.sv
// Short descriptor queue between the front and back ends of the escaper.
// Depends on jse_pkg.
`default_nettype none

module jse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jse_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output jse_pkg::desc_t desc_o
);
  import jse_pkg::*;

  desc_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q;
  logic [QueuePtrW-1:0]  rd_ptr_q;
  logic [QueueCntW-1:0]  count_q;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign desc_o  = slot_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> src/jse_back.sv
// Back end of the escaper: walks one descriptor at a time and sends its
// characters through a registered output stage. Depends on jse_pkg.
`default_nettype none

module jse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jse_pkg::desc_t     desc_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jse_pkg::out_item_t out_item_o
);
  import jse_pkg::*;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_HELD,
    PH_TAIL
  } phase_e;

  phase_e               phase_q;
  logic [HeldIdxW-1:0]  idx_q;
  logic [2:0]           sub_q;
  out_item_t            out_q;
  logic                 out_valid_q;

  phase_e               phase;
  logic                 advance;
  logic [7:0]           esc_byte;
  logic [7:0]           ch;
  logic                 done;
  logic                 seg_end;
  logic                 item_end;
  logic                 held_last;

  // Skip segments that this descriptor does not have.
  always_comb begin
    phase = phase_q;
    if ((phase == PH_OPEN) && !desc_i.open_quote) begin
      phase = PH_HELD;
    end
    if ((phase == PH_HELD) && (desc_i.held_n == '0)) begin
      phase = PH_TAIL;
    end
  end

  assign held_last = (idx_q == (desc_i.held_n - 2'd1));
  assign esc_byte  = (phase == PH_HELD) ? desc_i.held[idx_q] : desc_i.tail_byte;

  // Current character and where it stands in its segment.
  always_comb begin
    ch       = ChQuote;
    done     = 1'b0;
    seg_end  = 1'b1;
    item_end = 1'b0;
    case (sub_q)
      3'd0:    ch = ChBackslash;
      3'd1:    ch = ChLowerU;
      3'd2:    ch = ChZero;
      3'd3:    ch = ChZero;
      3'd4:    ch = hex_char(esc_byte[7:4]);
      default: ch = hex_char(esc_byte[3:0]);
    endcase
    case (phase)
      PH_OPEN: begin
        ch       = ChQuote;
        item_end = (desc_i.held_n == '0) && (desc_i.tail == TAIL_NONE);
      end
      PH_HELD: begin
        if (desc_i.held_esc) begin
          seg_end = (sub_q == HexEscLast);
        end else begin
          ch = desc_i.held[idx_q];
        end
        item_end = seg_end && held_last && (desc_i.tail == TAIL_NONE);
      end
      default: begin
        item_end = 1'b1;
        case (desc_i.tail)
          TAIL_PASS: ch = desc_i.tail_byte;
          TAIL_SHORT: begin
            ch       = (sub_q == 3'd0) ? ChBackslash : desc_i.tail_byte;
            seg_end  = (sub_q == ShortEscLast);
            item_end = seg_end;
          end
          TAIL_HEX: begin
            seg_end  = (sub_q == HexEscLast);
            item_end = seg_end;
          end
          default: begin
            ch   = ChQuote;
            done = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign advance     = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o       = advance && item_end;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Position within the descriptor and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      idx_q       <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q         <= 1'b1;
        out_q.out_byte      <= ch;
        out_q.string_done   <= done;
        out_q.run_last      <= item_end;
        if (item_end) begin
          phase_q <= PH_OPEN;
          idx_q   <= '0;
          sub_q   <= '0;
        end else if (!seg_end) begin
          phase_q <= phase;
          sub_q   <= sub_q + 3'd1;
        end else if ((phase == PH_HELD) && !held_last) begin
          phase_q <= PH_HELD;
          idx_q   <= idx_q + 2'd1;
          sub_q   <= '0;
        end else if (phase == PH_OPEN) begin
          phase_q <= PH_HELD;
          sub_q   <= '0;
        end else begin
          phase_q <= PH_TAIL;
          sub_q   <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_pop_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_o && out_item_o.run_last))
    else $error("descriptor retired without a last character");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.string_done) |-> out_item_o.run_last)
    else $error("closing quote not marked last");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(pop_o) |-> ((phase_q == PH_OPEN) && (idx_q == '0) && (sub_q == '0)))
    else $error("position not cleared after a descriptor");

endmodule

`default_nettype wire

>>> src/json_string_escaper_utf8.sv
// Top level of the streaming JSON string escaper with UTF-8 checking.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
//   Channel  Handshake               Payload
//   input    in_valid_i / in_ready_o  in_item_i  (kind, data_byte)
//   output   out_valid_o / out_ready_i out_item_o (out_byte, string_done, run_last)
//
// The back end sends one character per cycle while the queue is not empty
// and the output is not stalled. An item produces one character for plain
// text, two for a short escape, six for each \u00XX escape, plus one for an
// opening or closing quote. Items that only extend a UTF-8 sequence produce
// nothing. The front end accepts one item per cycle while the four-entry
// descriptor queue has room. Reset clears the sequence state, the queue and
// the output register at once; there is no clearing pass.
`default_nettype none

module json_string_escaper_utf8 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jse_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jse_pkg::out_item_t out_item_o
);
  import jse_pkg::*;

  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  desc_t desc_in;
  desc_t desc_out;

  jse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (desc_in)
  );

  jse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .desc_o  (desc_out)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
